@@ src/dfsec_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfsec_pkg: shared definitions of the DFS edge classifier
// Default sizes, action and edge kind codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dfsec_pkg;

  // Default graph size.
  localparam int VERTICES_DEF   = 16;
  localparam int MAX_DEGREE_DEF = 4;

  // Fixed field widths of the stream payload.
  localparam int FIELD_W  = 4;
  localparam int KIND_W   = 2;
  localparam int ACTION_W = 2;

  // Operation carried by an input transfer.
  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR_ALL   = 2'd0,
    ACT_ADD_EDGE    = 2'd1,
    ACT_CLEAR_MARKS = 2'd2,
    ACT_RUN         = 2'd3
  } action_e;

  // Classification of an examined edge.
  typedef enum logic [KIND_W-1:0] {
    KIND_TREE    = 2'd0,
    KIND_FORWARD = 2'd1,
    KIND_BACK    = 2'd2,
    KIND_CROSS   = 2'd3
  } kind_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_NBR,
    ST_CLASS,
    ST_POP,
    ST_FLUSH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // input transfer taken this cycle
    logic start;     // discover the root and open a run
    logic nbr_read;  // fetch the next neighbor of the current vertex
    logic ord_read;  // fetch the discovery order of the fetched neighbor
    logic classify;  // classify the edge and emit it to the pending slot
    logic finish;    // finish the current vertex and pop if possible
    logic pop_load;  // load the popped stack frame
    logic flush;     // move the final pending edge out with the last mark
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic root_ok;     // run root in range and not yet discovered
    logic has_edge;    // current vertex has an unexamined edge
    logic depth_zero;  // no suspended frame on the stack
    logic pend_valid;  // an edge waits in the pending slot
    logic out_free;    // output register can take an edge this cycle
  } status_t;

endpackage
`default_nettype wire

@@ src/dfsec_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfsec_ram: generic simple dual-port RAM
// One write port and one read port with registered, enable-held read data.
// ----------------------------------------------------------------------------
module dfsec_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is requested.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ src/dfsec_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfsec_ctrl: search sequencer of the DFS edge classifier
// Takes input transfers while idle and steps the datapath through the
// fetch, classify, finish and pop steps of a depth-first run.
// ----------------------------------------------------------------------------
module dfsec_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire dfsec_pkg::action_e  in_action_i,
  input  wire dfsec_pkg::status_t  status_i,
  output logic                     in_ready_o,
  output dfsec_pkg::cmd_t          cmd_o
);

  dfsec_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfsec_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      dfsec_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_action_i == dfsec_pkg::ACT_RUN && status_i.root_ok) begin
            cmd_o.start = 1'b1;
            state_d     = dfsec_pkg::ST_CHECK;
          end
        end
      end
      dfsec_pkg::ST_CHECK: begin
        if (status_i.has_edge) begin
          cmd_o.nbr_read = 1'b1;
          state_d        = dfsec_pkg::ST_NBR;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = status_i.depth_zero ? dfsec_pkg::ST_FLUSH : dfsec_pkg::ST_POP;
        end
      end
      dfsec_pkg::ST_NBR: begin
        cmd_o.ord_read = 1'b1;
        state_d        = dfsec_pkg::ST_CLASS;
      end
      dfsec_pkg::ST_CLASS: begin
        // The older pending edge must find room in the output register.
        if (!status_i.pend_valid || status_i.out_free) begin
          cmd_o.classify = 1'b1;
          state_d        = dfsec_pkg::ST_CHECK;
        end
      end
      dfsec_pkg::ST_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d        = dfsec_pkg::ST_CHECK;
      end
      dfsec_pkg::ST_FLUSH: begin
        if (!status_i.pend_valid) begin
          state_d = dfsec_pkg::ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = dfsec_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dfsec_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/dfsec_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfsec_datapath: graph store, marks, stack and result registers
// Holds the neighbor lists, vertex marks and the search stack, classifies
// edges and keeps one edge pending so the last of a run can be marked.
// ----------------------------------------------------------------------------
module dfsec_datapath #(
  parameter int VERTICES   = dfsec_pkg::VERTICES_DEF,
  parameter int MAX_DEGREE = dfsec_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire dfsec_pkg::action_e             in_action_i,
  input  wire logic [dfsec_pkg::FIELD_W-1:0]  in_from_i,
  input  wire logic [dfsec_pkg::FIELD_W-1:0]  in_to_i,
  input  wire dfsec_pkg::cmd_t                cmd_i,
  output dfsec_pkg::status_t                  status_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [dfsec_pkg::FIELD_W-1:0]       out_source_o,
  output logic [dfsec_pkg::FIELD_W-1:0]       out_target_o,
  output dfsec_pkg::kind_e                    out_kind_o,
  output logic                                out_last_o
);

  localparam int FW  = dfsec_pkg::FIELD_W;
  localparam int VW  = $clog2(VERTICES);
  localparam int DW  = $clog2(MAX_DEGREE + 1);
  localparam int NE  = VERTICES * MAX_DEGREE;
  localparam int AW  = $clog2(NE);
  localparam int CW  = $clog2(VERTICES + 1);
  localparam int SFW = VW + DW + VW;

  // Marks, degrees and counters (reset state).
  logic [DW-1:0]       deg_q [VERTICES];
  logic [DW-1:0]       deg_d [VERTICES];
  logic [VERTICES-1:0] disc_q, disc_d;
  logic [VERTICES-1:0] fin_q, fin_d;
  logic [CW-1:0]       counter_q, counter_d;
  logic [VW-1:0]       depth_q, depth_d;
  logic                out_valid_q, out_valid_d;
  logic                pend_valid_q, pend_valid_d;

  // Current frame and result payload.
  logic [VW-1:0]       here_q, here_d;
  logic [DW-1:0]       slot_q, slot_d;
  logic [VW-1:0]       here_ord_q, here_ord_d;
  logic [VW-1:0]       pend_src_q, pend_dst_q;
  dfsec_pkg::kind_e    pend_kind_q;
  logic [FW-1:0]       out_src_q, out_dst_q;
  dfsec_pkg::kind_e    out_kind_q;
  logic                out_last_q;

  logic                from_ok, to_ok, add_ok;
  logic [VW-1:0]       from_idx, to_idx;
  logic [VW-1:0]       there, ord_rdata;
  logic [SFW-1:0]      stk_rdata;
  dfsec_pkg::kind_e    kind;
  logic                is_tree;
  logic                nbr_we, ord_we, stk_we, stk_re;
  logic [AW-1:0]       nbr_waddr, nbr_raddr;
  logic [VW-1:0]       ord_waddr;

  // Input decoding.
  assign from_ok  = 32'(in_from_i) < 32'(VERTICES);
  assign to_ok    = 32'(in_to_i) < 32'(VERTICES);
  assign from_idx = VW'(in_from_i);
  assign to_idx   = VW'(in_to_i);
  assign add_ok   = from_ok && to_ok && (deg_q[from_idx] < DW'(MAX_DEGREE));

  // Edge classification against the fetched neighbor.
  always_comb begin
    if (!disc_q[there]) begin
      kind = dfsec_pkg::KIND_TREE;
    end else if (here_ord_q < ord_rdata) begin
      kind = dfsec_pkg::KIND_FORWARD;
    end else if (!fin_q[there]) begin
      kind = dfsec_pkg::KIND_BACK;
    end else begin
      kind = dfsec_pkg::KIND_CROSS;
    end
  end
  assign is_tree = cmd_i.classify && (kind == dfsec_pkg::KIND_TREE);

  // Neighbor lists.
  assign nbr_we    = cmd_i.accept && (in_action_i == dfsec_pkg::ACT_ADD_EDGE) && add_ok;
  assign nbr_waddr = AW'(int'(from_idx) * MAX_DEGREE + int'(deg_q[from_idx]));
  assign nbr_raddr = AW'(int'(here_q) * MAX_DEGREE + int'(slot_q));

  dfsec_ram #(.WIDTH(VW), .DEPTH(NE)) u_nbr_ram (
    .clk_i   (clk_i),
    .we_i    (nbr_we),
    .waddr_i (nbr_waddr),
    .wdata_i (to_idx),
    .re_i    (cmd_i.nbr_read),
    .raddr_i (nbr_raddr),
    .rdata_o (there)
  );

  // Discovery order, read at the fetched neighbor.
  assign ord_we    = cmd_i.start || is_tree;
  assign ord_waddr = cmd_i.start ? from_idx : there;

  dfsec_ram #(.WIDTH(VW), .DEPTH(VERTICES)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (VW'(counter_q)),
    .re_i    (cmd_i.ord_read),
    .raddr_i (there),
    .rdata_o (ord_rdata)
  );

  // Stack of suspended frames: vertex, next slot and discovery order.
  assign stk_we = is_tree;
  assign stk_re = cmd_i.finish && (depth_q != '0);

  dfsec_ram #(.WIDTH(SFW), .DEPTH(VERTICES)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (depth_q),
    .wdata_i ({here_q, slot_q + DW'(1), here_ord_q}),
    .re_i    (stk_re),
    .raddr_i (depth_q - VW'(1)),
    .rdata_o (stk_rdata)
  );

  // Next state of marks, counters and the current frame.
  always_comb begin
    deg_d        = deg_q;
    disc_d       = disc_q;
    fin_d        = fin_q;
    counter_d    = counter_q;
    depth_d      = depth_q;
    here_d       = here_q;
    slot_d       = slot_q;
    here_ord_d   = here_ord_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    pend_valid_d = pend_valid_q;
    if (cmd_i.accept) begin
      unique case (in_action_i)
        dfsec_pkg::ACT_CLEAR_ALL: begin
          for (int i = 0; i < VERTICES; i++) begin
            deg_d[i] = '0;
          end
          disc_d    = '0;
          fin_d     = '0;
          counter_d = '0;
        end
        dfsec_pkg::ACT_ADD_EDGE: begin
          if (add_ok) begin
            deg_d[from_idx] = deg_q[from_idx] + DW'(1);
          end
        end
        dfsec_pkg::ACT_CLEAR_MARKS: begin
          disc_d    = '0;
          fin_d     = '0;
          counter_d = '0;
        end
        dfsec_pkg::ACT_RUN: begin
          if (cmd_i.start) begin
            disc_d[from_idx] = 1'b1;
            counter_d        = counter_q + CW'(1);
            depth_d          = '0;
            here_d           = from_idx;
            slot_d           = '0;
            here_ord_d       = VW'(counter_q);
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.classify) begin
      slot_d       = slot_q + DW'(1);
      pend_valid_d = 1'b1;
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
      end
      if (is_tree) begin
        disc_d[there] = 1'b1;
        counter_d     = counter_q + CW'(1);
        depth_d       = depth_q + VW'(1);
        here_d        = there;
        slot_d        = '0;
        here_ord_d    = VW'(counter_q);
      end
    end
    if (cmd_i.finish) begin
      fin_d[here_q] = 1'b1;
      if (depth_q != '0) begin
        depth_d = depth_q - VW'(1);
      end
    end
    if (cmd_i.pop_load) begin
      {here_d, slot_d, here_ord_d} = stk_rdata;
    end
    if (cmd_i.flush) begin
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VERTICES; i++) begin
        deg_q[i] <= '0;
      end
      disc_q       <= '0;
      fin_q        <= '0;
      counter_q    <= '0;
      depth_q      <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      deg_q        <= deg_d;
      disc_q       <= disc_d;
      fin_q        <= fin_d;
      counter_q    <= counter_d;
      depth_q      <= depth_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // Frame and result payload registers.
  always_ff @(posedge clk_i) begin
    here_q     <= here_d;
    slot_q     <= slot_d;
    here_ord_q <= here_ord_d;
    if (cmd_i.classify) begin
      pend_src_q  <= here_q;
      pend_dst_q  <= there;
      pend_kind_q <= kind;
    end
    if ((cmd_i.classify && pend_valid_q) || cmd_i.flush) begin
      out_src_q  <= FW'(pend_src_q);
      out_dst_q  <= FW'(pend_dst_q);
      out_kind_q <= pend_kind_q;
      out_last_q <= cmd_i.flush;
    end
  end

  // Status toward the controller.
  assign status_o.root_ok    = from_ok && !disc_q[from_idx];
  assign status_o.has_edge   = slot_q < deg_q[here_q];
  assign status_o.depth_zero = (depth_q == '0);
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_source_o = out_src_q;
  assign out_target_o = out_dst_q;
  assign out_kind_o   = out_kind_q;
  assign out_last_o   = out_last_q;

endmodule
`default_nettype wire

@@ src/dfs_edge_classifier.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_edge_classifier: depth-first search edge classifier
// Loads a directed graph edge by edge and, on a run from a root, walks it
// depth first and reports every examined edge as tree, forward, back or cross.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata (low bit up)               tuser       tlast
// s_axis    in   from_vertex[3:0], to_vertex[7:4]  action[1:0] -
// m_axis    out  edge_source[3:0], edge_target[7:4] edge_kind  last_of_run
//
// Clear, add-edge and clear-marks commands complete as they are taken.
// A run starts at the root, then steps through neighbor fetch, order fetch
// and classify for each examined edge, finish and stack pop for each
// finished vertex below the root, and finish and flush for the root; the
// fetch and pop steps wait on the registered reads of the neighbor, order
// and stack memories. Output stalls hold the classify and flush steps;
// input is taken only between runs.
// Reset is asynchronous, active low, and empties the graph and all marks.
// ----------------------------------------------------------------------------
module dfs_edge_classifier #(
  parameter int VERTICES   = dfsec_pkg::VERTICES_DEF,
  parameter int MAX_DEGREE = dfsec_pkg::MAX_DEGREE_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // from_vertex[3:0], to_vertex[7:4]
  input  wire logic [1:0] s_axis_tuser_i,   // action[1:0]
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // edge_source[3:0], edge_target[7:4]
  output logic [1:0]      m_axis_tuser_o,   // edge_kind[1:0]
  output logic            m_axis_tlast_o    // last_of_run
);

  dfsec_pkg::cmd_t    cmd;
  dfsec_pkg::status_t status;
  dfsec_pkg::action_e action;
  dfsec_pkg::kind_e   kind;

  assign action = dfsec_pkg::action_e'(s_axis_tuser_i);

  // Sequencer.
  dfsec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_action_i (action),
    .status_i    (status),
    .in_ready_o  (s_axis_tready_o),
    .cmd_o       (cmd)
  );

  // Graph store, marks, stack and result registers.
  dfsec_datapath #(
    .VERTICES   (VERTICES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_action_i  (action),
    .in_from_i    (s_axis_tdata_i[3:0]),
    .in_to_i      (s_axis_tdata_i[7:4]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_source_o (m_axis_tdata_o[3:0]),
    .out_target_o (m_axis_tdata_o[7:4]),
    .out_kind_o   (kind),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = kind;

endmodule
`default_nettype wire

@@ src/dfsec_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfsec_checker: port-level checks of the DFS edge classifier
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module dfsec_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic [1:0] s_axis_tuser_i,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic [1:0] m_axis_tuser_o,
  input wire logic       m_axis_tlast_o
);

  // A stalled result keeps its payload until the transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("result payload changed while stalled");

  // Commands other than a run finish at once, so input stays open.
  a_cmd_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i != dfsec_pkg::ACT_RUN)
      |=> s_axis_tready_o)
    else $error("input closed after a non-run command");

  // A result that is not the last of its run means the run is still going.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input open while a run still has results");

  // A tree edge always enters a fresh vertex, so it is never a self loop.
  a_tree_no_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == dfsec_pkg::KIND_TREE) |->
      m_axis_tdata_o[7:4] != m_axis_tdata_o[3:0])
    else $error("tree edge reported as a self loop");

endmodule

bind dfs_edge_classifier dfsec_checker u_dfsec_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the DFS edge classifier
// Streams clear, add-edge, clear-marks and run commands into the block, keeps
// its own copy of the graph and search marks to predict every classified
// edge, and checks each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int NV = dfsec_pkg::VERTICES_DEF;
  localparam int ND = dfsec_pkg::MAX_DEGREE_DEF;

  // One command as the sender presents it.
  typedef struct {
    dfsec_pkg::action_e act;
    logic [3:0]         src_v;
    logic [3:0]         dst_v;
    int unsigned        gap;    // idle cycles before the transfer
    bit                 drain;  // hold off until every predicted edge has arrived
  } graph_op_t;

  // One classified edge.
  typedef struct {
    logic [3:0]       src;
    logic [3:0]       dst;
    dfsec_pkg::kind_e kind;
    logic             last;
  } arc_t;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = '0;  // from_vertex[3:0], to_vertex[7:4]
  logic [1:0] s_axis_tuser_i  = '0;  // action[1:0]
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;        // edge_source[3:0], edge_target[7:4]
  logic [1:0] m_axis_tuser_o;        // edge_kind[1:0]
  logic       m_axis_tlast_o;        // last_of_run

  dfs_edge_classifier u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the graph and of the search marks.
  logic [3:0]  nbr [NV][ND];
  int unsigned deg [NV];
  bit          seen [NV];
  bit          done [NV];
  int unsigned order [NV];
  int unsigned disc_count;

  graph_op_t cmd_q[$];     // commands waiting for the sender
  arc_t      arcs_due[$];  // classified edges predicted but not yet seen
  graph_op_t tx_cur;
  int        n_err = 0;
  int        gap_max = 0;
  bit        drain_next = 1'b0;
  int        rx_wait = 0;
  int        rx_mode_left = 0;
  bit        rx_busy_mode = 1'b0;

  // Apply one accepted command to the shadow state and queue the edges a run
  // classifies, in the order the search examines them.
  function automatic void predict_arcs(graph_op_t op);
    int unsigned      stk_v [NV];
    int unsigned      stk_s [NV];
    int               depth;
    int unsigned      here;
    int unsigned      there;
    dfsec_pkg::kind_e k;
    arc_t             a;
    arc_t             run_arcs[$];
    case (op.act) inside
      dfsec_pkg::ACT_CLEAR_ALL, dfsec_pkg::ACT_CLEAR_MARKS: begin
        if (op.act == dfsec_pkg::ACT_CLEAR_ALL) begin
          foreach (deg[v]) deg[v] = 0;
        end
        foreach (seen[v]) begin
          seen[v] = 1'b0;
          done[v] = 1'b0;
        end
        disc_count = 0;
      end
      dfsec_pkg::ACT_ADD_EDGE: begin
        // A full neighbor list drops the edge.
        if (deg[op.src_v] < ND) begin
          nbr[op.src_v][deg[op.src_v]] = op.dst_v;
          deg[op.src_v]++;
        end
      end
      default: begin
        // A root that is already discovered gives nothing.
        if (!seen[op.src_v]) begin
          seen[op.src_v]  = 1'b1;
          order[op.src_v] = disc_count;
          disc_count++;
          stk_v[0] = op.src_v;
          stk_s[0] = 0;
          depth    = 1;
          while (depth > 0) begin
            here = stk_v[depth-1];
            if (stk_s[depth-1] < deg[here]) begin
              there = nbr[here][stk_s[depth-1]];
              stk_s[depth-1]++;
              if (!seen[there]) k = dfsec_pkg::KIND_TREE;
              else if (order[here] < order[there]) k = dfsec_pkg::KIND_FORWARD;
              else if (!done[there]) k = dfsec_pkg::KIND_BACK;
              else k = dfsec_pkg::KIND_CROSS;
              a.src  = here[3:0];
              a.dst  = there[3:0];
              a.kind = k;
              a.last = 1'b0;
              run_arcs.push_back(a);
              // Descend only after the tree edge is reported.
              if (k == dfsec_pkg::KIND_TREE) begin
                seen[there]  = 1'b1;
                order[there] = disc_count;
                disc_count++;
                stk_v[depth] = there;
                stk_s[depth] = 0;
                depth++;
              end
            end else begin
              done[here] = 1'b1;
              depth--;
            end
          end
          if (run_arcs.size() > 0) run_arcs[run_arcs.size()-1].last = 1'b1;
          foreach (run_arcs[i]) arcs_due.push_back(run_arcs[i]);
        end
      end
    endcase
  endfunction

  task automatic queue_op(dfsec_pkg::action_e act, int unsigned src, int unsigned dst);
    graph_op_t op;
    op.act     = act;
    op.src_v   = src[3:0];
    op.dst_v   = dst[3:0];
    op.gap     = $urandom_range(0, gap_max);
    op.drain   = drain_next;
    drain_next = 1'b0;
    cmd_q.push_back(op);
  endtask

  // Sender: presents queued commands, predicting on each completed transfer.
  always @(posedge clk_i) begin : drive_proc
    logic valid_nxt;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      valid_nxt = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_arcs(tx_cur);
        valid_nxt = 1'b0;
      end
      if (!valid_nxt && cmd_q.size() > 0) begin
        if (cmd_q[0].drain && arcs_due.size() != 0) begin
          // Wait for the outstanding edges before the next command.
        end else if (cmd_q[0].gap > 0) begin
          cmd_q[0].gap = cmd_q[0].gap - 1;
        end else begin
          tx_cur = cmd_q.pop_front();
          s_axis_tdata_i <= {tx_cur.dst_v, tx_cur.src_v};
          s_axis_tuser_i <= tx_cur.act;
          valid_nxt = 1'b1;
        end
      end
      s_axis_tvalid_i <= valid_nxt;
    end
  end

  // Receiver: checks each output transfer and stalls in random stretches.
  always @(posedge clk_i) begin : watch_proc
    arc_t got;
    arc_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.src  = m_axis_tdata_o[3:0];
        got.dst  = m_axis_tdata_o[7:4];
        got.kind = dfsec_pkg::kind_e'(m_axis_tuser_o);
        got.last = m_axis_tlast_o;
        if (arcs_due.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch at %0t: unexpected edge %0d->%0d kind %0d last %0b",
                     $realtime, got.src, got.dst, got.kind, got.last);
        end else begin
          want = arcs_due.pop_front();
          if (got.src !== want.src || got.dst !== want.dst ||
              got.kind !== want.kind || got.last !== want.last) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch at %0t: want %0d->%0d k%0d l%0b, got %0d->%0d k%0d l%0b",
                       $realtime, want.src, want.dst, want.kind, want.last,
                       got.src, got.dst, got.kind, got.last);
          end
        end
        // Alternate between stalling and streaming stretches.
        if (rx_mode_left == 0) begin
          rx_busy_mode = $urandom_range(0, 1);
          rx_mode_left = $urandom_range(8, 40);
        end
        rx_mode_left--;
        rx_wait = rx_busy_mode ? $urandom_range(0, 9) : 0;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned nv;
    int unsigned base;
    int unsigned n_edges;
    int unsigned n_runs;
    foreach (deg[v]) begin
      deg[v]   = 0;
      seen[v]  = 1'b0;
      done[v]  = 1'b0;
      order[v] = 0;
    end
    disc_count = 0;

    // Directed: every edge kind, duplicates, a full list, self loop,
    // a repeated root, a root without edges and both clear commands.
    gap_max = 9;
    queue_op(dfsec_pkg::ACT_CLEAR_ALL, 15, 15);
    queue_op(dfsec_pkg::ACT_ADD_EDGE, 0, 1);
    queue_op(dfsec_pkg::ACT_ADD_EDGE, 1, 2);
    queue_op(dfsec_pkg::ACT_ADD_EDGE, 2, 0);
    queue_op(dfsec_pkg::ACT_ADD_EDGE, 0, 2);
    queue_op(dfsec_pkg::ACT_ADD_EDGE, 1, 2);
    queue_op(dfsec_pkg::ACT_ADD_EDGE, 0, 15);
    queue_op(dfsec_pkg::ACT_ADD_EDGE, 0, 14);
    queue_op(dfsec_pkg::ACT_ADD_EDGE, 0, 13);
    queue_op(dfsec_pkg::ACT_ADD_EDGE, 15, 15);
    queue_op(dfsec_pkg::ACT_RUN, 0, 9);
    drain_next = 1'b1;
    queue_op(dfsec_pkg::ACT_RUN, 0, 0);
    gap_max = 0;
    queue_op(dfsec_pkg::ACT_ADD_EDGE, 3, 1);
    queue_op(dfsec_pkg::ACT_RUN, 3, 6);
    queue_op(dfsec_pkg::ACT_RUN, 7, 0);
    queue_op(dfsec_pkg::ACT_CLEAR_MARKS, 10, 5);
    queue_op(dfsec_pkg::ACT_RUN, 3, 0);
    queue_op(dfsec_pkg::ACT_ADD_EDGE, 14, 3);
    queue_op(dfsec_pkg::ACT_CLEAR_MARKS, 0, 0);
    queue_op(dfsec_pkg::ACT_RUN, 14, 15);
    queue_op(dfsec_pkg::ACT_CLEAR_ALL, 0, 0);
    queue_op(dfsec_pkg::ACT_RUN, 0, 0);
    queue_op(dfsec_pkg::ACT_ADD_EDGE, 15, 0);
    queue_op(dfsec_pkg::ACT_RUN, 15, 0);

    // One graph at full size: a ring through every vertex keeps it all
    // reachable, so one run walks every edge of the full neighbor lists.
    gap_max = 9;
    queue_op(dfsec_pkg::ACT_CLEAR_ALL, $urandom_range(0, 15), $urandom_range(0, 15));
    for (int v = 0; v < NV; v++) begin
      queue_op(dfsec_pkg::ACT_ADD_EDGE, v, (v + 1) % NV);
      for (int j = 1; j < ND; j++)
        queue_op(dfsec_pkg::ACT_ADD_EDGE, v, $urandom_range(0, 15));
    end
    queue_op(dfsec_pkg::ACT_ADD_EDGE, $urandom_range(0, 15), $urandom_range(0, 15));
    queue_op(dfsec_pkg::ACT_RUN, $urandom_range(0, 15), $urandom_range(0, 15));
    queue_op(dfsec_pkg::ACT_CLEAR_MARKS, $urandom_range(0, 15), $urandom_range(0, 15));
    queue_op(dfsec_pkg::ACT_RUN, $urandom_range(0, 15), $urandom_range(0, 15));

    // Random: mostly small graphs built and searched, some stray commands.
    while (cmd_q.size() < 175) begin
      gap_max    = $urandom_range(0, 1) ? 9 : 0;
      drain_next = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) < 7) begin
        nv      = $urandom_range(2, 8);
        base    = $urandom_range(0, 15);
        n_edges = $urandom_range(2, 14);
        n_runs  = $urandom_range(1, 4);
        queue_op(dfsec_pkg::ACT_CLEAR_ALL, $urandom_range(0, 15), $urandom_range(0, 15));
        repeat (n_edges)
          queue_op(dfsec_pkg::ACT_ADD_EDGE, (base + $urandom_range(0, nv - 1)) % NV,
                   (base + $urandom_range(0, nv - 1)) % NV);
        repeat (n_runs) begin
          if ($urandom_range(0, 3) == 0)
            queue_op(dfsec_pkg::ACT_CLEAR_MARKS, $urandom_range(0, 15),
                     $urandom_range(0, 15));
          queue_op(dfsec_pkg::ACT_RUN, (base + $urandom_range(0, nv - 1)) % NV,
                   $urandom_range(0, 15));
        end
      end else begin
        repeat ($urandom_range(1, 6))
          queue_op(dfsec_pkg::action_e'($urandom_range(0, 3)), $urandom_range(0, 15),
                   $urandom_range(0, 15));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (arcs_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (n_err == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
